FILE: rtl/core/pdc_pkg.sv
// pdc_pkg: shared types and constants for the PWM duty capture block.
// No dependencies; imported by pwm_duty_capture_top.

package pdc_pkg;

	// timestamp bits actually used for the period and high-time math
	localparam int TIME_BITS  = 32;
	// port width of timestamps and tick counts
	localparam int TICK_BITS  = 32;
	localparam int DUTY_BITS  = 10;
	localparam int DUTY_SCALE = 1000;
	// high*1000 + period/2 stays below 1024 * 2^TIME_BITS
	localparam int NUM_W      = TIME_BITS + DUTY_BITS;
	localparam int STEP_W     = $clog2(DUTY_BITS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = 1'b1;

	localparam logic [CFG_DATA_W-1:0] MIN_DUTY_RST = 10'd0;
	localparam logic [CFG_DATA_W-1:0] MAX_DUTY_RST = 10'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} pdc_state_t;

endpackage

FILE: rtl/core/pwm_duty_capture_top.sv
// pwm_duty_capture_top: edge-driven PWM period, high time and duty measurement.
// Depends on pdc_pkg; contains the sequencer and the serial restoring divider.
//
// Usage:
//   Input channel (in_valid/in_stall, edge_time, level_after) carries one PWM
//   edge per transfer. Falling edges and rising edges that close no pulse leave
//   in_stall low.
//   A rising edge that closes a pulse starts a measurement: period and high time
//   are captured at the transfer edge, a check step tests them and forms
//   high*1000+period/2, then the DUTY_BITS (10) quotient bits are formed in the
//   shared compare/subtract unit of the divider, then a final step moves the
//   result into the output register once it is free; in_stall is high
//   throughout.
//   A rejected pulse (zero period or high time above period) ends after the
//   check step with no result.
//   Output channel (out_valid/out_stall, high_cnt, period_cnt, duty_pm,
//   in_range) holds each result until it is taken. New edges are accepted while
//   a result waits; a following measurement waits in its last step until the
//   output register is free.
//   Configuration: cfg_we writes cfg_data into threshold cfg_index at once.
//   Reset clears the edge history and loads the thresholds to 0 and 1000.

module pwm_duty_capture_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pdc_pkg::TICK_BITS-1:0]  edge_time,
	input  logic                           level_after,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pdc_pkg::TICK_BITS-1:0]  high_cnt,
	output logic [pdc_pkg::TICK_BITS-1:0]  period_cnt,
	output logic [pdc_pkg::DUTY_BITS-1:0]  duty_pm,
	output logic                           in_range
);
	import pdc_pkg::*;

	pdc_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] min_duty_q, max_duty_q;

	logic [TIME_BITS-1:0] last_rise_q, fall_time_q;
	logic                 rise_seen_q, fall_seen_q;

	logic [TIME_BITS-1:0] period_q, high_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [DUTY_BITS-1:0] quo_q;
	logic [STEP_W-1:0]    step_q;

	logic                 out_valid_q;
	logic [TICK_BITS-1:0] out_high_q, out_period_q;
	logic [DUTY_BITS-1:0] out_duty_q;
	logic                 out_in_range_q;

	logic                 in_xfer, rise_in, pulse_close;
	logic                 pulse_bad;
	logic                 out_free, load_out;
	logic [TIME_BITS-1:0] t_in;
	logic [NUM_W-1:0]     num;
	logic [TIME_BITS:0]   trial, trial_sub;
	logic                 trial_ge;
	logic                 range_ok;

	assign t_in        = edge_time[TIME_BITS-1:0];
	assign in_stall    = (state_q != ST_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign rise_in     = in_xfer && level_after;
	assign pulse_close = rise_in && rise_seen_q && fall_seen_q;

	assign pulse_bad = (period_q == '0) || (high_q > period_q);
	assign num = NUM_W'(high_q) * NUM_W'(DUTY_SCALE) + NUM_W'(period_q >> 1);

	// one restoring step: bring down the next numerator bit, subtract if it fits
	assign trial     = {rem_q, quo_q[DUTY_BITS-1]};
	assign trial_sub = trial - {1'b0, period_q};
	assign trial_ge  = (trial >= {1'b0, period_q});

	assign out_free = !out_valid_q || !out_stall;
	assign range_ok = (min_duty_q <= max_duty_q) && (quo_q >= min_duty_q)
		&& (quo_q <= max_duty_q);

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pulse_close) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = pulse_bad ? ST_IDLE : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DUTY_BITS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q <= MIN_DUTY_RST;
			max_duty_q <= MAX_DUTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_DUTY: min_duty_q <= cfg_data;
				REG_MAX_DUTY: max_duty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// edge history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rise_q <= '0;
			fall_time_q <= '0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
		end else if (in_xfer) begin
			if (level_after) begin
				last_rise_q <= t_in;
				rise_seen_q <= 1'b1;
				fall_seen_q <= 1'b0;
			end else if (rise_seen_q) begin
				fall_time_q <= t_in;
				fall_seen_q <= 1'b1;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (pulse_close) begin
			period_q <= t_in - last_rise_q;
			high_q   <= fall_time_q - last_rise_q;
		end
		if (state_q == ST_PREP) begin
			// quotient fits DUTY_BITS, so the top part is already below period
			rem_q  <= num[NUM_W-1:DUTY_BITS];
			quo_q  <= num[DUTY_BITS-1:0];
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= trial_ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q  <= {quo_q[DUTY_BITS-2:0], trial_ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_high_q     <= TICK_BITS'(high_q);
			out_period_q   <= TICK_BITS'(period_q);
			out_duty_q     <= quo_q;
			out_in_range_q <= range_ok;
		end
	end

	assign out_valid  = out_valid_q;
	assign high_cnt   = out_high_q;
	assign period_cnt = out_period_q;
	assign duty_pm    = out_duty_q;
	assign in_range   = out_in_range_q;

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_pm <= DUTY_BITS'(DUTY_SCALE)))
		else $error("duty above full scale");

	a_pulse_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (period_cnt != '0) && (high_cnt <= period_cnt))
		else $error("rejected pulse reached the output");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the final step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid && out_stall |=> (state_q == ST_DONE))
		else $error("pending result overwritten");

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for pwm_duty_capture_top: directed edge table, then random pulse trains.
// Depends on pdc_pkg and pwm_duty_capture_top; predicts each measurement and compares on transfer.

module tb;

	import pdc_pkg::*;

	typedef struct {
		logic [TICK_BITS-1:0] high_cnt;
		logic [TICK_BITS-1:0] period_cnt;
		logic [DUTY_BITS-1:0] duty_pm;
		logic                 in_range;
	} meas_t;

	typedef enum {ROW_QUIET, ROW_TYPED, ROW_MODEL} row_kind_t;

	typedef struct {
		logic [TICK_BITS-1:0] t;
		logic                 lvl;
		row_kind_t            kind;
		logic [TICK_BITS-1:0] hi;
		logic [TICK_BITS-1:0] per;
		logic [DUTY_BITS-1:0] duty;
		logic                 ok;
	} edge_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [TICK_BITS-1:0]  edge_time;
	logic                  level_after;
	logic                  out_valid;
	logic                  out_stall;
	logic [TICK_BITS-1:0]  high_cnt;
	logic [TICK_BITS-1:0]  period_cnt;
	logic [DUTY_BITS-1:0]  duty_pm;
	logic                  in_range;

	// predictor state
	logic [TICK_BITS-1:0]  prev_rise;
	logic [TICK_BITS-1:0]  held_fall;
	logic                  have_rise;
	logic                  have_fall;
	logic [CFG_DATA_W-1:0] duty_lo;
	logic [CFG_DATA_W-1:0] duty_hi;

	meas_t       pending_meas[$];
	int unsigned err_count;
	bit          send_quiet;
	bit          take_quiet;

	// expected values typed only where they follow from reset thresholds (0..1000)
	edge_row_t directed_rows [0:25] = '{
		'{32'd100,        1'b0, ROW_QUIET, 0, 0, 0, 0},    // fall before any rise
		'{32'd100,        1'b1, ROW_QUIET, 0, 0, 0, 0},
		'{32'd150,        1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd200,        1'b1, ROW_TYPED, 50, 100, 500, 1'b1},
		'{32'hFFFF_FF00,  1'b1, ROW_QUIET, 0, 0, 0, 0},    // rise with no fall stored
		'{32'hFFFF_FF80,  1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd0,          1'b1, ROW_TYPED, 128, 256, 500, 1'b1}, // timer wrap
		'{32'd10,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd10,         1'b1, ROW_TYPED, 10, 10, 1000, 1'b1},
		'{32'd10,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd20,         1'b1, ROW_TYPED, 0, 10, 0, 1'b1},
		'{32'd30,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd20,         1'b1, ROW_QUIET, 0, 0, 0, 0},    // zero period
		'{32'd50,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd40,         1'b1, ROW_QUIET, 0, 0, 0, 0},    // high above period
		'{32'd45,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd47,         1'b0, ROW_QUIET, 0, 0, 0, 0},    // latest fall wins
		'{32'd60,         1'b1, ROW_TYPED, 7, 20, 350, 1'b1},
		'{32'd61,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd63,         1'b1, ROW_TYPED, 1, 3, 333, 1'b1},
		'{32'd65,         1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd66,         1'b1, ROW_TYPED, 2, 3, 667, 1'b1},   // rounds up
		'{32'h8000_0041,  1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd65,         1'b1, ROW_MODEL, 0, 0, 0, 0},    // full-scale period
		'{32'hFFFF_FFFF,  1'b0, ROW_QUIET, 0, 0, 0, 0},
		'{32'd64,         1'b1, ROW_MODEL, 0, 0, 0, 0}
	};

	pwm_duty_capture_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.edge_time   (edge_time),
		.level_after (level_after),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.high_cnt    (high_cnt),
		.period_cnt  (period_cnt),
		.duty_pm     (duty_pm),
		.in_range    (in_range)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// per-item wait, with occasional runs of zero wait
	function automatic int unsigned pick_wait(inout bit quiet);
		if ($urandom_range(0, 49) == 0)
			quiet = ~quiet;
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// update edge history; queue a measurement when a pulse closes cleanly
	function automatic void track_edge(logic [TICK_BITS-1:0] t_raw, logic lvl, bit keep);
		logic [TICK_BITS-1:0] t;
		logic [TICK_BITS-1:0] per;
		logic [TICK_BITS-1:0] hi;
		logic [63:0]          num;
		logic [63:0]          duty;
		meas_t                m;
		t = t_raw & TICK_BITS'((64'd1 << TIME_BITS) - 64'd1);
		if (!lvl) begin
			if (have_rise) begin
				held_fall = t;
				have_fall = 1'b1;
			end
			return;
		end
		if (have_rise && have_fall) begin
			per = t - prev_rise;
			hi  = held_fall - prev_rise;
			if (per != 0 && hi <= per) begin
				num  = {32'b0, hi} * 64'd1000 + {32'b0, per} / 64'd2;
				duty = num / {32'b0, per};
				m.high_cnt   = hi;
				m.period_cnt = per;
				m.duty_pm    = duty[DUTY_BITS-1:0];
				m.in_range   = (duty_lo <= duty_hi) && (duty >= 64'(duty_lo)) &&
					(duty <= 64'(duty_hi));
				if (keep)
					pending_meas.push_back(m);
			end
		end
		prev_rise = t;
		have_rise = 1'b1;
		have_fall = 1'b0;
	endfunction

	// one edge transfer; in_valid stays high into the next call when no gap is drawn
	task automatic send_edge(logic [TICK_BITS-1:0] t, logic lvl);
		int unsigned gap;
		gap = pick_wait(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		edge_time   <= t;
		level_after <= lvl;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and let every pending measurement drain
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_meas.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_thresholds(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_DUTY;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_MAX_DUTY;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		duty_lo = lo;
		duty_hi = hi;
	endtask

	// mostly clean rise/fall/rise trains; some noise, broken pulses and drains
	task automatic send_pulses(int unsigned count);
		int unsigned          sent;
		int unsigned          sel;
		logic [TICK_BITS-1:0] cur;
		logic [TICK_BITS-1:0] per;
		logic [TICK_BITS-1:0] hi;
		logic                 lvl;
		logic [TICK_BITS-1:0] t;
		sent = 0;
		cur  = prev_rise;
		while (sent < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				t   = $urandom;
				lvl = 1'($urandom_range(0, 1));
				send_edge(t, lvl);
				track_edge(t, lvl, 1'b1);
				if (lvl)
					cur = t;
				sent++;
			end else if (sel < 9) begin
				drain();
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 60)
					per = $urandom_range(1, 1000);
				else if (sel < 85)
					per = $urandom_range(1, 1 << 20);
				else
					per = $urandom;
				hi = TICK_BITS'({32'b0, $urandom} % ({32'b0, per} + 64'd1));
				sel = $urandom_range(0, 99);
				if (sel < 4)
					per = '0;
				else if (sel < 8)
					hi = per + 1 + $urandom_range(0, 100);
				if ($urandom_range(0, 99) < 15) begin
					send_edge(cur + hi / 2, 1'b0);
					track_edge(cur + hi / 2, 1'b0, 1'b1);
					sent++;
				end
				if ($urandom_range(0, 99) >= 10) begin
					send_edge(cur + hi, 1'b0);
					track_edge(cur + hi, 1'b0, 1'b1);
					sent++;
				end
				cur = cur + per;
				send_edge(cur, 1'b1);
				track_edge(cur, 1'b1, 1'b1);
				sent++;
			end
		end
	endtask

	// result side: random stalls per transfer
	initial begin
		int unsigned hold;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			hold = pick_wait(take_quiet);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		meas_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_meas.size() == 0) begin
				$error("unexpected result: high %0d period %0d duty %0d", high_cnt,
					period_cnt, duty_pm);
				err_count++;
			end else begin
				want = pending_meas.pop_front();
				if (high_cnt !== want.high_cnt) begin
					$error("high_cnt: expected %0d, got %0d", want.high_cnt, high_cnt);
					err_count++;
				end
				if (period_cnt !== want.period_cnt) begin
					$error("period_cnt: expected %0d, got %0d", want.period_cnt,
						period_cnt);
					err_count++;
				end
				if (duty_pm !== want.duty_pm) begin
					$error("duty_pm: expected %0d, got %0d", want.duty_pm, duty_pm);
					err_count++;
				end
				if (in_range !== want.in_range) begin
					$error("in_range: expected %0d, got %0d", want.in_range, in_range);
					err_count++;
				end
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] lo_set [0:7];
		logic [CFG_DATA_W-1:0] hi_set [0:7];
		meas_t                 m;
		lo_set = '{10'd0, 10'd1000, 10'd500, 10'd1023, 10'd0, 10'd1000, 10'd250, 10'd0};
		hi_set = '{10'd1000, 10'd0, 10'd500, 10'd1023, 10'd0, 10'd1000, 10'd750, 10'd0};
		lo_set[7] = $urandom_range(0, 1023);
		hi_set[7] = $urandom_range(0, 1023);
		err_count   = 0;
		send_quiet  = 1'b0;
		take_quiet  = 1'b0;
		prev_rise   = '0;
		held_fall   = '0;
		have_rise   = 1'b0;
		have_fall   = 1'b0;
		duty_lo     = MIN_DUTY_RST;
		duty_hi     = MAX_DUTY_RST;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_MIN_DUTY;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		edge_time   <= '0;
		level_after <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_edge(directed_rows[i].t, directed_rows[i].lvl);
			track_edge(directed_rows[i].t, directed_rows[i].lvl,
				directed_rows[i].kind == ROW_MODEL);
			if (directed_rows[i].kind == ROW_TYPED) begin
				m.high_cnt   = directed_rows[i].hi;
				m.period_cnt = directed_rows[i].per;
				m.duty_pm    = directed_rows[i].duty;
				m.in_range   = directed_rows[i].ok;
				pending_meas.push_back(m);
			end
		end
		drain();

		foreach (lo_set[p]) begin
			set_thresholds(lo_set[p], hi_set[p]);
			send_pulses(150);
			drain();
		end

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
